FILE: rtl/kqss_pkg.sv
`default_nettype none

package kqss_pkg;

    localparam int CMD_W    = 1;
    localparam int QID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // largest queue number the input field can carry
    localparam int QID_MAX = (1 << QID_W) - 1;

    localparam int ENTRIES_DEF = 16;
    localparam int QUEUES_DEF  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DEQ
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/kqss_if.sv
`default_nettype none

interface kqss_req_if;
    logic                                valid;
    logic                                ready;
    logic [kqss_pkg::CMD_W-1:0]          command;
    logic [kqss_pkg::QID_W-1:0]          queue_id;
    logic signed [kqss_pkg::DATA_W-1:0]  data_in;

    modport source (output valid, output command, output queue_id, output data_in,
                    input ready);
    modport sink   (input valid, input command, input queue_id, input data_in,
                    output ready);
endinterface

interface kqss_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [kqss_pkg::DATA_W-1:0]  data_out;
    logic [kqss_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/k_queues_shared_store.sv
`default_nettype none

// QUEUES fifo queues sharing one store of ENTRIES words, kept as linked lists with a
// common free list. Each request (enqueue or dequeue on a queue) gives exactly one
// response carrying data_out and status (ok, overflow when the store is full,
// underflow when the queue is empty). One request is in flight at a time: an enqueue
// or an error registers its response from the lookup step, a successful dequeue from
// a further dequeue step, because its head pointer must come out of the queue
// pointer memory before the link and payload memories can be read at that entry.
// A new request is taken in the cycle after the response is registered, even while
// that response still waits at the output. Queue numbers at or above QUEUES wrap
// modulo QUEUES. No clearing pass is needed after reset: untouched link entries are
// recognized by a fill count.
module k_queues_shared_store #(
    parameter int ENTRIES = kqss_pkg::ENTRIES_DEF,
    parameter int QUEUES  = kqss_pkg::QUEUES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    kqss_req_if.sink     i_req,
    kqss_rsp_if.source   o_rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int PW = $clog2(ENTRIES + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int DW = kqss_pkg::DATA_W;
    localparam int RW = 9;  // wide enough to compare against a queue count below 512
    localparam logic [PW-1:0] PTR_NONE = PW'(ENTRIES);

    // memories
    logic [2*PW-1:0] qptr_mem [QUEUES];   // {head, tail}
    logic [PW-1:0]   link_mem [ENTRIES];
    logic [DW-1:0]   pay_mem  [ENTRIES];

    // registers
    kqss_pkg::t_state  r_state, n_state;
    kqss_pkg::t_cmd    r_cmd;
    logic [QW-1:0]     r_q;
    logic [DW-1:0]     r_data;
    logic [PW-1:0]     r_free, n_free;
    logic [PW-1:0]     r_fill, n_fill;
    logic [QUEUES-1:0] r_qvalid;
    logic [2*PW-1:0]   r_qrd;
    logic [PW-1:0]     r_link_rd;
    logic [DW-1:0]     r_pay_rd;
    logic              r_out_valid;
    logic [DW-1:0]     r_out_data;
    kqss_pkg::t_status r_out_status;

    // control
    logic              accept;
    logic [QW-1:0]     q_in;
    logic [RW-1:0]     q_red;
    logic [PW-1:0]     q_head, q_tail, free_link;
    logic              head_ok, tail_ok, free_ok, fin_ok;
    logic              qw_en, lw_en, lr_en, pw_en, pr_en;
    logic [2*PW-1:0]   qw_data;
    logic [IW-1:0]     lw_addr, lr_addr;
    logic [PW-1:0]     lw_data;
    logic              fin;
    logic [DW-1:0]     fin_data;
    kqss_pkg::t_status fin_status;

    assign i_req.ready = (r_state == kqss_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // queue number modulo QUEUES by repeated subtract
    always_comb begin
        q_red = RW'(i_req.queue_id);
        for (int k = 0; k < kqss_pkg::QID_MAX; k++) begin
            if (q_red >= RW'(QUEUES)) begin
                q_red = q_red - RW'(QUEUES);
            end
        end
        q_in = q_red[QW-1:0];
    end

    assign q_head  = r_qvalid[r_q] ? r_qrd[2*PW-1:PW] : PTR_NONE;
    assign q_tail  = r_qvalid[r_q] ? r_qrd[PW-1:0]    : PTR_NONE;
    assign head_ok = (q_head < PTR_NONE);
    assign tail_ok = (q_tail < PTR_NONE);
    assign free_ok = (r_free < PTR_NONE);
    assign fin_ok  = !r_out_valid || o_rsp.ready;

    // entries at or past the fill count were never written; their link is taken as the next entry
    assign free_link = (r_free >= r_fill) ? (r_free + PW'(1)) : r_link_rd;

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_fill     = r_fill;
        qw_en      = 1'b0;
        qw_data    = '0;
        lw_en      = 1'b0;
        lw_addr    = '0;
        lw_data    = '0;
        lr_en      = 1'b0;
        lr_addr    = r_free[IW-1:0];
        pw_en      = 1'b0;
        pr_en      = 1'b0;
        fin        = 1'b0;
        fin_data   = '0;
        fin_status = kqss_pkg::ST_OK;
        unique case (r_state)
            kqss_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = kqss_pkg::S_LOOK;
                    lr_en   = free_ok;
                end
            end
            kqss_pkg::S_LOOK: begin
                if (r_cmd == kqss_pkg::CMD_ENQ) begin
                    if (fin_ok) begin
                        fin     = 1'b1;
                        n_state = kqss_pkg::S_IDLE;
                        if (!free_ok) begin
                            fin_status = kqss_pkg::ST_OVERFLOW;
                        end else begin
                            pw_en   = 1'b1;
                            n_free  = free_link;
                            if (r_free == r_fill) begin
                                n_fill = r_fill + PW'(1);
                            end
                            qw_en   = 1'b1;
                            qw_data = {head_ok ? q_head : r_free, r_free};
                            if (head_ok && tail_ok) begin
                                lw_en   = 1'b1;
                                lw_addr = q_tail[IW-1:0];
                                lw_data = r_free;
                            end
                        end
                    end
                end else begin
                    if (!head_ok) begin
                        if (fin_ok) begin
                            fin        = 1'b1;
                            fin_status = kqss_pkg::ST_UNDERFLOW;
                            n_state    = kqss_pkg::S_IDLE;
                        end
                    end else begin
                        lr_en   = 1'b1;
                        lr_addr = q_head[IW-1:0];
                        pr_en   = 1'b1;
                        n_state = kqss_pkg::S_DEQ;
                    end
                end
            end
            kqss_pkg::S_DEQ: begin
                if (fin_ok) begin
                    fin      = 1'b1;
                    fin_data = r_pay_rd;
                    n_state  = kqss_pkg::S_IDLE;
                    // the tail entry is the last one, its link is never needed
                    qw_en    = 1'b1;
                    qw_data  = {(q_head == q_tail) ? PTR_NONE : r_link_rd, q_tail};
                    lw_en    = 1'b1;
                    lw_addr  = q_head[IW-1:0];
                    lw_data  = r_free;
                    n_free   = q_head;
                end
            end
            default: begin
                n_state = kqss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kqss_pkg::S_IDLE;
            r_free   <= '0;
            r_fill   <= '0;
            r_qvalid <= '0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_fill  <= n_fill;
            if (qw_en) begin
                r_qvalid[r_q] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= kqss_pkg::t_cmd'(i_req.command);
            r_q    <= q_in;
            r_data <= i_req.data_in;
        end
    end

    // queue pointer memory
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qrd <= qptr_mem[q_in];
        end
        if (qw_en) begin
            qptr_mem[r_q] <= qw_data;
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (lr_en) begin
            r_link_rd <= link_mem[lr_addr];
        end
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (pr_en) begin
            r_pay_rd <= pay_mem[q_head[IW-1:0]];
        end
        if (pw_en) begin
            pay_mem[r_free[IW-1:0]] <= r_data;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_data   <= fin_data;
            r_out_status <= fin_status;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.data_out = $signed(r_out_data);
    assign o_rsp.status   = r_out_status;

`ifndef SYNTH
    // an empty free list means every entry has been handed out at least once
    a_free_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == PTR_NONE) |-> (r_fill == PTR_NONE))
        else $error("free list empty while fill count below store size");

    // the dequeue step only runs on a queue that was found non-empty
    a_deq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kqss_pkg::S_DEQ) |-> (r_qvalid[r_q] && head_ok))
        else $error("dequeue step on an empty queue");

    // a response appears only after a request has been looked up
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != kqss_pkg::S_IDLE))
        else $error("response raised without a request in flight");

    // a transfer always moves to the lookup step
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == kqss_pkg::S_LOOK))
        else $error("request transfer did not start a lookup");
`endif

endmodule

`default_nettype wire
